// ===== sv/integer_to_ascii_digits_unit_defines.svh =====
// Assertion macros for the integer-to-ASCII digit unit.
// Used by the port checker; no other dependencies.
`ifndef INTEGER_TO_ASCII_DIGITS_UNIT_DEFINES_SVH
`define INTEGER_TO_ASCII_DIGITS_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define IAD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("iad check failed: same-cycle rule");

// Next-cycle implication, checked outside reset
`define IAD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("iad check failed: next-cycle rule");

`endif

// ===== sv/iad_pkg.sv =====
// Shared types, constants and helpers for the integer-to-ASCII digit unit.
// No dependencies; the design files and the checker refer to it by scoped names.
package iad_pkg;

    // Field widths and defaults
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int CMD_W           = 2;
    localparam int NUMBER_W        = 32;
    localparam int CHAR_W          = 8;

    // Number bases; a hex digit is also the BCD digit width
    localparam int DEC_BASE = 10;
    localparam int HEX_BASE = 16;
    localparam int DIGIT_W  = $clog2(HEX_BASE);

    // Shift-add-3 bit steps done per converter cycle
    localparam int DAB_STEPS = 4;

    // Entries in the queue between front and converter
    localparam int QUEUE_DEPTH = 2;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_SIGNED_DEC   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_UNSIGNED_DEC = 2'd1;
    localparam logic [CMD_W-1:0] CMD_HEX          = 2'd2;

    // ASCII codes
    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;

    typedef struct packed {
        logic [CMD_W-1:0]    command;
        logic [NUMBER_W-1:0] number;
    } iad_in_t;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
    } iad_out_t;

    // Classification of one number, carried with its magnitude
    typedef struct packed {
        logic neg;
        logic hex;
    } iad_flags_t;

    typedef enum logic [1:0] {
        CV_IDLE,
        CV_RUN,
        CV_HOLD
    } iad_conv_state_t;

    typedef enum logic [1:0] {
        EM_IDLE,
        EM_SIGN,
        EM_DIGIT
    } iad_emit_state_t;

    // Decimal digits needed for any w-bit unsigned value (1233/4096 ~ log10 2)
    function automatic int dec_digits(int w);
        return (w * 1233) / 4096 + 1;
    endfunction

    // ASCII code of one digit, 0-9 then a-f
    function automatic logic [CHAR_W-1:0] digit_char(logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] dx;
        dx = CHAR_W'(d);
        if (d < DIGIT_W'(DEC_BASE))
            return CHAR_ZERO + dx;
        else
            return CHAR_LOWER_A + dx - CHAR_W'(DEC_BASE);
    endfunction

endpackage

// ===== sv/integer_to_ascii_digits_unit.sv =====
// Top level of the integer-to-ASCII digit unit: front, converter, emitter.
// Depends on iad_pkg, iad_front, iad_conv, iad_emit.
//
//   channel | signals                        | beat
//   --------+--------------------------------+-------------------------------
//   num     | num_valid, num_ready, num_data | command and 32-bit number
//   chr     | chr_valid, chr_ready, chr_data | one ASCII character, last flag
//
// Decimal magnitudes are converted by shift-add-3, four bit steps per converter cycle;
// hex magnitudes pass straight through. The emitter sends one character per cycle while
// chr_ready is high and overlaps the converter; a hex number gives 1 to 8 characters at
// 32 bits.
// Reset (rst_n, asynchronous) empties the queue and idles both state machines.
// A stalled chr beat holds the emitter, then the converter; the queue takes two more.
module integer_to_ascii_digits_unit #(
    parameter int VALUE_WIDTH = iad_pkg::VALUE_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              num_valid,
    output logic              num_ready,
    input  iad_pkg::iad_in_t  num_data,
    output logic              chr_valid,
    input  logic              chr_ready,
    output iad_pkg::iad_out_t chr_data
);

    localparam int BW = iad_pkg::dec_digits(VALUE_WIDTH) * iad_pkg::DIGIT_W;

    // front to converter
    logic                   q_valid, q_ready;
    iad_pkg::iad_flags_t    q_flags;
    logic [VALUE_WIDTH-1:0] q_mag;

    // converter to emitter
    logic          d_valid, d_ready;
    logic          d_neg;
    logic [BW-1:0] d_digits;

    iad_front #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (num_valid),
        .in_ready  (num_ready),
        .in_data   (num_data),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_flags (q_flags),
        .out_mag   (q_mag)
    );

    iad_conv #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_conv (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (q_valid),
        .in_ready   (q_ready),
        .in_flags   (q_flags),
        .in_mag     (q_mag),
        .out_valid  (d_valid),
        .out_ready  (d_ready),
        .out_neg    (d_neg),
        .out_digits (d_digits)
    );

    iad_emit #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d_valid),
        .in_ready  (d_ready),
        .in_neg    (d_neg),
        .in_digits (d_digits),
        .out_valid (chr_valid),
        .out_ready (chr_ready),
        .out_data  (chr_data)
    );

endmodule

// ===== sv/iad_front.sv =====
// Front end: takes number beats, works out sign and magnitude, and queues them.
// Depends on iad_pkg.
module iad_front #(
    parameter int VALUE_WIDTH = iad_pkg::VALUE_WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  iad_pkg::iad_in_t          in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output iad_pkg::iad_flags_t       out_flags,
    output logic [VALUE_WIDTH-1:0]    out_mag
);

    localparam int QD    = iad_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (QD > 1) ? $clog2(QD) : 1;
    localparam int CNT_W = $clog2(QD + 1);

    logic [VALUE_WIDTH-1:0] mag_q [QD];
    iad_pkg::iad_flags_t    flags_q [QD];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic                   push, pop;
    logic [VALUE_WIDTH-1:0] value;
    logic [VALUE_WIDTH-1:0] mag;
    iad_pkg::iad_flags_t    flags;

    // Classify: only signed decimal with the top bit set is negative
    always_comb
    begin
        value     = VALUE_WIDTH'(in_data.number);
        flags.hex = in_data.command[1];
        flags.neg = (in_data.command == iad_pkg::CMD_SIGNED_DEC) && value[VALUE_WIDTH-1];
        // the most negative value negates to itself, which is its magnitude
        mag       = flags.neg ? (~value + VALUE_WIDTH'(1)) : value;
    end

    assign in_ready  = (count_reg != CNT_W'(QD));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_flags = flags_q[rd_ptr_reg];
    assign out_mag   = mag_q[rd_ptr_reg];

    // Queue pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QD - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QD - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mag_q[wr_ptr_reg]   <= mag;
            flags_q[wr_ptr_reg] <= flags;
        end
    end

endmodule

// ===== sv/iad_conv.sv =====
// Converter: turns a magnitude into packed digits, decimal by shift-add-3.
// Hex magnitudes pass straight through. Depends on iad_pkg.
module iad_conv #(
    parameter int VALUE_WIDTH = iad_pkg::VALUE_WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  iad_pkg::iad_flags_t       in_flags,
    input  logic [VALUE_WIDTH-1:0]    in_mag,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      out_neg,
    output logic [iad_pkg::dec_digits(VALUE_WIDTH)*iad_pkg::DIGIT_W-1:0] out_digits
);

    localparam int DW   = iad_pkg::DIGIT_W;
    localparam int NDIG = iad_pkg::dec_digits(VALUE_WIDTH);
    localparam int BW   = NDIG * DW;
    localparam int STEP = iad_pkg::DAB_STEPS;
    localparam int CYC  = (VALUE_WIDTH + STEP - 1) / STEP;
    localparam int PW   = CYC * STEP;
    localparam int CW   = (CYC > 1) ? $clog2(CYC) : 1;

    iad_pkg::iad_conv_state_t state_reg, state_next;
    logic [PW-1:0] bin_reg, bin_next;
    logic [BW-1:0] bcd_reg, bcd_next;
    logic          neg_reg, neg_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    logic [PW-1:0] bin_w;
    logic [BW-1:0] bcd_w;
    logic          load;

    // Several shift-add-3 steps per cycle
    always_comb
    begin
        bin_w = bin_reg;
        bcd_w = bcd_reg;
        for (int s = 0; s < STEP; s++)
        begin
            for (int d = 0; d < NDIG; d++)
            begin
                if (bcd_w[d*DW +: DW] >= DW'(5))
                    bcd_w[d*DW +: DW] = bcd_w[d*DW +: DW] + DW'(3);
            end
            bcd_w = {bcd_w[BW-2:0], bin_w[PW-1]};
            bin_w = {bin_w[PW-2:0], 1'b0};
        end
    end

    assign in_ready   = (state_reg == iad_pkg::CV_IDLE) ||
                        ((state_reg == iad_pkg::CV_HOLD) && out_ready);
    assign load       = in_valid && in_ready;
    assign out_valid  = (state_reg == iad_pkg::CV_HOLD);
    assign out_neg    = neg_reg;
    assign out_digits = bcd_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        bin_next   = bin_reg;
        bcd_next   = bcd_reg;
        neg_next   = neg_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            iad_pkg::CV_IDLE:
            begin
            end
            iad_pkg::CV_RUN:
            begin
                bin_next = bin_w;
                bcd_next = bcd_w;
                if (cnt_reg == CW'(CYC - 1))
                    state_next = iad_pkg::CV_HOLD;
                else
                    cnt_next = cnt_reg + CW'(1);
            end
            iad_pkg::CV_HOLD:
            begin
                if (out_ready)
                    state_next = iad_pkg::CV_IDLE;
            end
            default:
            begin
                state_next = iad_pkg::CV_IDLE;
            end
        endcase
        // a new beat may enter as the held result leaves
        if (load)
        begin
            neg_next = in_flags.neg;
            cnt_next = '0;
            if (in_flags.hex)
            begin
                bcd_next   = BW'(PW'(in_mag));
                state_next = iad_pkg::CV_HOLD;
            end
            else
            begin
                bin_next   = PW'(in_mag);
                bcd_next   = '0;
                state_next = iad_pkg::CV_RUN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= iad_pkg::CV_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
        neg_reg <= neg_next;
    end

endmodule

// ===== sv/iad_emit.sv =====
// Emitter: sends the sign and then the digits, top nonzero digit first.
// Depends on iad_pkg.
module iad_emit #(
    parameter int VALUE_WIDTH = iad_pkg::VALUE_WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      in_neg,
    input  logic [iad_pkg::dec_digits(VALUE_WIDTH)*iad_pkg::DIGIT_W-1:0] in_digits,
    output logic                      out_valid,
    input  logic                      out_ready,
    output iad_pkg::iad_out_t         out_data
);

    localparam int DW   = iad_pkg::DIGIT_W;
    localparam int NDIG = iad_pkg::dec_digits(VALUE_WIDTH);
    localparam int BW   = NDIG * DW;
    localparam int IW   = $clog2(NDIG);

    iad_pkg::iad_emit_state_t state_reg, state_next;
    logic [BW-1:0] digits_reg, digits_next;
    logic [IW-1:0] idx_reg, idx_next;

    logic [IW-1:0] top_idx;
    logic [DW-1:0] cur_digit;
    logic          last_digit;
    logic          load;

    // Highest nonzero digit; zero itself leaves one digit
    always_comb
    begin
        top_idx = '0;
        for (int i = 0; i < NDIG; i++)
        begin
            if (in_digits[i*DW +: DW] != '0)
                top_idx = IW'(i);
        end
    end

    assign cur_digit  = digits_reg[idx_reg*DW +: DW];
    assign last_digit = (state_reg == iad_pkg::EM_DIGIT) && (idx_reg == '0);
    assign out_valid  = (state_reg != iad_pkg::EM_IDLE);
    assign in_ready   = (state_reg == iad_pkg::EM_IDLE) || (last_digit && out_ready);
    assign load       = in_valid && in_ready;

    always_comb
    begin
        out_data.character = (state_reg == iad_pkg::EM_SIGN) ? iad_pkg::CHAR_MINUS
                                                              : iad_pkg::digit_char(cur_digit);
        out_data.last      = last_digit;
    end

    // Next state
    always_comb
    begin
        state_next  = state_reg;
        digits_next = digits_reg;
        idx_next    = idx_reg;
        unique case (state_reg)
            iad_pkg::EM_IDLE:
            begin
            end
            iad_pkg::EM_SIGN:
            begin
                if (out_ready)
                    state_next = iad_pkg::EM_DIGIT;
            end
            iad_pkg::EM_DIGIT:
            begin
                if (out_ready)
                begin
                    if (idx_reg == '0)
                        state_next = iad_pkg::EM_IDLE;
                    else
                        idx_next = idx_reg - IW'(1);
                end
            end
            default:
            begin
                state_next = iad_pkg::EM_IDLE;
            end
        endcase
        // next number follows the last digit without a gap
        if (load)
        begin
            digits_next = in_digits;
            idx_next    = top_idx;
            state_next  = in_neg ? iad_pkg::EM_SIGN : iad_pkg::EM_DIGIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= iad_pkg::EM_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        digits_reg <= digits_next;
    end

endmodule

// ===== sv/iad_checker.sv =====
// Port checker for the integer-to-ASCII digit unit, bound to the top level.
// Depends on iad_pkg and integer_to_ascii_digits_unit_defines.svh.
`include "integer_to_ascii_digits_unit_defines.svh"

module iad_checker #(
    parameter int VALUE_WIDTH = iad_pkg::VALUE_WIDTH_DEF
) (
    input logic              clk,
    input logic              rst_n,
    input logic              chr_valid,
    input logic              chr_ready,
    input iad_pkg::iad_out_t chr_data
);

    // most characters one number can give: sign plus all decimal digits
    localparam int MAXB = iad_pkg::dec_digits(VALUE_WIDTH) + 1;
    localparam int CW   = $clog2(MAXB + 1);

    logic [CW-1:0] cnt_reg, cnt_next;
    logic          beat, stall, first, is_minus, is_zero, last, lead_digit;

    assign beat       = chr_valid && chr_ready;
    assign stall      = chr_valid && !chr_ready;
    assign first      = (cnt_reg == '0);
    assign is_minus   = (chr_data.character == iad_pkg::CHAR_MINUS);
    assign is_zero    = (chr_data.character == iad_pkg::CHAR_ZERO);
    assign last       = chr_data.last;
    // a nonzero digit on offer
    assign lead_digit = chr_valid && !is_minus && !is_zero;

    // characters already taken from the current number
    always_comb
    begin
        cnt_next = cnt_reg;
        if (beat)
            cnt_next = last ? '0 : cnt_reg + CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    `IAD_ASSERT_NEXT(a_stall_hold, clk, rst_n, stall, chr_valid && $stable(chr_data))
    `IAD_ASSERT_NEXT(a_minus_then_digit, clk, rst_n, beat && is_minus, lead_digit)
    `IAD_ASSERT_IMPLY(a_minus_first, clk, rst_n, chr_valid && is_minus, first && !last)
    `IAD_ASSERT_IMPLY(a_lone_zero, clk, rst_n, chr_valid && first && is_zero, last)
    `IAD_ASSERT_IMPLY(a_max_chars, clk, rst_n, chr_valid && !last, cnt_reg < CW'(MAXB - 1))

endmodule

bind integer_to_ascii_digits_unit iad_checker #(
    .VALUE_WIDTH(VALUE_WIDTH)
) u_iad_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .chr_valid (chr_valid),
    .chr_ready (chr_ready),
    .chr_data  (chr_data)
);
